[design/dfir_pkg.sv]
package dfir_pkg;

	// Filter geometry
	localparam int TAP_COUNT    = 81;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ROM_TAPS     = 81;
	localparam int COEF_WIDTH   = 18;
	localparam int COEF_FRAC    = 17;
	localparam int TAP_W        = $clog2(TAP_COUNT);
	localparam int ADDR_W       = $clog2(TAP_COUNT);
	localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W        = PROD_W + $clog2(TAP_COUNT);

	// Decimation register
	localparam int                DECIM_W     = 5;
	localparam logic [DECIM_W-1:0] DECIM_RESET = DECIM_W'(10);
	localparam logic [DECIM_W-1:0] DECIM_MAX   = DECIM_W'(16);
	localparam int                PHASE_W     = 4;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} dfir_state_t;

	// Symmetric low-pass taps, Q1.17, tap 0 meets the newest sample
	localparam logic signed [COEF_WIDTH-1:0] COEF_ROM [ROM_TAPS] = '{
		18'sd79, 18'sd69, 18'sd50, 18'sd23, -18'sd15, -18'sd62, -18'sd116, -18'sd171,
		-18'sd218, -18'sd246, -18'sd242, -18'sd195, -18'sd100, 18'sd44, 18'sd226,
		18'sd430, 18'sd626, 18'sd781, 18'sd860, 18'sd828, 18'sd662, 18'sd353, -18'sd89,
		-18'sd631, -18'sd1218, -18'sd1775, -18'sd2214, -18'sd2444, -18'sd2379,
		-18'sd1950, -18'sd1116, 18'sd130, 18'sd1751, 18'sd3674, 18'sd5788, 18'sd7953,
		18'sd10015, 18'sd11818, 18'sd13222, 18'sd14113, 18'sd14418,
		18'sd14113, 18'sd13222, 18'sd11818, 18'sd10015, 18'sd7953, 18'sd5788,
		18'sd3674, 18'sd1751, 18'sd130, -18'sd1116, -18'sd1950, -18'sd2379,
		-18'sd2444, -18'sd2214, -18'sd1775, -18'sd1218, -18'sd631, -18'sd89, 18'sd353,
		18'sd662, 18'sd828, 18'sd860, 18'sd781, 18'sd626, 18'sd430, 18'sd226, 18'sd44,
		-18'sd100, -18'sd195, -18'sd242, -18'sd246, -18'sd218, -18'sd171, -18'sd116,
		-18'sd62, -18'sd15, 18'sd23, 18'sd50, 18'sd69, 18'sd79
	};

	// Taps past the ROM carry a zero coefficient
	function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [TAP_W-1:0] k);
		logic signed [COEF_WIDTH-1:0] c;
		c = '0;
		if (int'(k) < ROM_TAPS) begin
			c = COEF_ROM[int'(k)];
		end
		return c;
	endfunction

endpackage

[design/dfir_ram.sv]
module dfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 81
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/decimating_fir_filter_core.sv]
// Decimating 81-tap low-pass FIR. Each item on the sample_in channel is one
// signed Q1.15 sample shifted into an 81-deep delay line (zero after reset).
// Every Nth sample (N = decimation_factor, 0 acts as 1, above 16 acts as 16)
// produces one rounded, saturated Q1.15 item on filtered_out; other samples
// produce nothing. A sample that produces no result leaves sample_in_ready high.
// A sample that produces a result holds sample_in_ready low after its accept
// until the result is loaded into the output register: one shared 16x18
// multiplier walks the 81 taps, one per cycle, out of the delay-line RAM, then
// the RAM-read and multiply stages drain and a rounding state follows. The
// rounding state stretches while the previous result still waits on filtered_out.
// Writing decimation_factor leaves the phase count and delay line as they are.
module decimating_fir_filter_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [dfir_pkg::DECIM_W-1:0]             cfg_wdata,
	input  logic                                     sample_in_valid,
	output logic                                     sample_in_ready,
	input  logic signed [dfir_pkg::SAMPLE_WIDTH-1:0] sample_in,
	output logic                                     filtered_out_valid,
	input  logic                                     filtered_out_ready,
	output logic signed [dfir_pkg::SAMPLE_WIDTH-1:0] filtered_out
);

	import dfir_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAP_COUNT - 1);
	localparam logic [TAP_W-1:0]  LAST_TAP  = TAP_W'(TAP_COUNT - 1);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

	dfir_state_t                   state_q, state_d;
	logic [DECIM_W-1:0]            decim_q;
	logic [PHASE_W-1:0]            phase_q;
	logic [ADDR_W-1:0]             newest_q;
	logic [ADDR_W-1:0]             wr_addr;
	logic [ADDR_W-1:0]             rd_addr_q;
	logic [TAP_W-1:0]              tap_q;
	logic [TAP_COUNT-1:0]          vld_q;
	logic                          rd_vld_s1;
	logic                          ent_vld_s1;
	logic signed [COEF_WIDTH-1:0]  coef_s1;
	logic [SAMPLE_WIDTH-1:0]       ram_rdata;
	logic signed [SAMPLE_WIDTH-1:0] op_s1;
	logic                          mul_vld_s2;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       rnd_sum;
	logic signed [ACC_W-1:0]       rnd_shift;
	logic signed [SAMPLE_WIDTH-1:0] sat_val;
	logic                          out_vld_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic [DECIM_W-1:0]            decim_n;
	logic                          in_acc;
	logic                          emit;
	logic                          issue;
	logic                          load_out;

	// Effective decimation, clamped to 1..16
	always_comb begin
		priority if (decim_q == '0) begin
			decim_n = DECIM_W'(1);
		end else if (decim_q > DECIM_MAX) begin
			decim_n = DECIM_MAX;
		end else begin
			decim_n = decim_q;
		end
	end

	assign in_acc  = sample_in_valid && sample_in_ready;
	assign emit    = ({1'b0, phase_q} + DECIM_W'(1)) >= decim_n;
	assign wr_addr = (newest_q == LAST_ADDR) ? '0 : newest_q + ADDR_W'(1);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		sample_in_ready = 1'b0;
		issue           = 1'b0;
		load_out        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_in_ready = 1'b1;
				if (sample_in_valid && emit) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				issue = 1'b1;
				if (tap_q == LAST_TAP) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_vld_s1 && !mul_vld_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || filtered_out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Config register, phase count, write pointer, entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q  <= DECIM_RESET;
			phase_q  <= '0;
			newest_q <= LAST_ADDR;
			vld_q    <= '0;
		end else begin
			if (cfg_we) begin
				decim_q <= cfg_wdata;
			end
			if (in_acc) begin
				newest_q       <= wr_addr;
				vld_q[wr_addr] <= 1'b1;
				phase_q        <= emit ? '0 : phase_q + PHASE_W'(1);
			end
		end
	end

	// Read address walks from newest toward oldest, tap index climbs
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_addr_q <= wr_addr;
			tap_q     <= '0;
		end else if (issue) begin
			rd_addr_q <= (rd_addr_q == '0) ? LAST_ADDR : rd_addr_q - ADDR_W'(1);
			tap_q     <= tap_q + TAP_W'(1);
		end
	end

	// Delay line storage
	dfir_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(TAP_COUNT)
	) u_dline (
		.clk  (clk),
		.we   (in_acc),
		.waddr(wr_addr),
		.wdata(sample_in),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// MAC pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			mul_vld_s2 <= rd_vld_s1;
		end
	end

	// Stage 1: coefficient and entry-valid alongside RAM data
	always_ff @(posedge clk) begin
		coef_s1    <= coef_at(tap_q);
		ent_vld_s1 <= vld_q[rd_addr_q];
	end

	// Never-written entries read as zero
	assign op_s1 = ent_vld_s1 ? $signed(ram_rdata) : '0;

	// Stage 2: shared multiplier
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(op_s1 * coef_s1);
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up, shift to Q1.15, saturate
	assign rnd_sum   = acc_q + RND_HALF;
	assign rnd_shift = rnd_sum >>> COEF_FRAC;
	always_comb begin
		priority if (rnd_shift > SAT_HI) begin
			sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (rnd_shift < SAT_LO) begin
			sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			sat_val = rnd_shift[SAMPLE_WIDTH-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (filtered_out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= sat_val;
		end
	end

	assign filtered_out_valid = out_vld_q;
	assign filtered_out       = out_q;

`ifndef NO_ASSERTIONS
	// An emitting sample starts a tap walk
	a_emit_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && emit) |=> (state_q == ST_MAC && tap_q == '0))
		else $error("emitting item did not start the tap walk");

	// Pointers stay inside the delay line
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(newest_q <= LAST_ADDR) && (rd_addr_q <= LAST_ADDR || state_q == ST_IDLE))
		else $error("delay line pointer out of range");

	// Rounding only sees a fully drained pipeline
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!rd_vld_s1 && !mul_vld_s2))
		else $error("result formed before MAC pipeline drained");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_vld_q || filtered_out_ready))
		else $error("output register overwritten while held");
`endif

endmodule

[tb/tb_decimating_fir_filter_core.sv]
module tb_decimating_fir_filter_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPS            = 81;
	localparam int FACTOR_AT_RESET = 10;
	localparam int FACTOR_CAP      = 16;
	localparam int SETTLE_CYCLES   = 100;
	localparam int STALL_CYCLES    = 600;
	localparam int CYCLE_LIMIT     = 400000;
	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

	// Low-pass taps in Q1.17, tap 0 meets the newest sample
	localparam int LP_COEF [TAPS] = '{
		79, 69, 50, 23, -15, -62, -116, -171, -218, -246,
		-242, -195, -100, 44, 226, 430, 626, 781, 860, 828,
		662, 353, -89, -631, -1218, -1775, -2214, -2444, -2379, -1950,
		-1116, 130, 1751, 3674, 5788, 7953, 10015, 11818, 13222, 14113,
		14418,
		14113, 13222, 11818, 10015, 7953, 5788, 3674, 1751, 130, -1116,
		-1950, -2379, -2444, -2214, -1775, -1218, -631, -89, 353, 662,
		828, 860, 781, 626, 430, 226, 44, -100, -195, -242,
		-246, -218, -171, -116, -62, -15, 23, 50, 69, 79
	};

	// Shapes of sample runs
	typedef enum int {
		AMP_NOISE,
		AMP_SMALL,
		AMP_HOLD,
		AMP_MATCH_HI,
		AMP_MATCH_LO,
		AMP_TOGGLE
	} burst_kind_t;

	logic                                     clk                = 1'b0;
	logic                                     arst_n             = 1'b0;
	logic                                     cfg_we             = 1'b0;
	logic [dfir_pkg::DECIM_W-1:0]             cfg_wdata          = '0;
	logic                                     sample_in_valid    = 1'b0;
	logic                                     sample_in_ready;
	logic signed [dfir_pkg::SAMPLE_WIDTH-1:0] sample_in          = '0;
	logic                                     filtered_out_valid;
	logic                                     filtered_out_ready = 1'b0;
	logic signed [dfir_pkg::SAMPLE_WIDTH-1:0] filtered_out;

	// Filter state as predicted
	logic signed [15:0] delay_taps [TAPS];
	logic [3:0]         phase_cnt  = '0;
	logic [4:0]         decim_reg  = 5'(FACTOR_AT_RESET);

	logic signed [15:0] pending_samples  [$];
	logic signed [15:0] expected_outputs [$];

	int  tx_idle_pct  = 0;
	int  rx_idle_pct  = 0;
	bit  stall_start  = 1'b0;
	int  stall_left   = 0;
	int  mismatches   = 0;
	int  samples_in   = 0;
	int  outputs_seen = 0;
	int  decim_writes = 0;
	int  cycle_cnt    = 0;

	decimating_fir_filter_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.sample_in_valid    (sample_in_valid),
		.sample_in_ready    (sample_in_ready),
		.sample_in          (sample_in),
		.filtered_out_valid (filtered_out_valid),
		.filtered_out_ready (filtered_out_ready),
		.filtered_out       (filtered_out)
	);

	always #2 clk = ~clk;

	// Shift one sample in; returns 1 with the decimated output when one is due
	function automatic bit filter_sample(input logic signed [15:0] s,
			output logic signed [15:0] y);
		int     n;
		int     k;
		longint acc;
		n = (decim_reg == 0) ? 1 : ((decim_reg > FACTOR_CAP) ? FACTOR_CAP : int'(decim_reg));
		for (k = TAPS - 1; k > 0; k--) begin
			delay_taps[k] = delay_taps[k-1];
		end
		delay_taps[0] = s;
		y = '0;
		if (int'(phase_cnt) + 1 < n) begin
			phase_cnt = phase_cnt + 4'd1;
			return 1'b0;
		end
		phase_cnt = '0;
		acc = 0;
		for (k = 0; k < TAPS; k++) begin
			acc += longint'(delay_taps[k]) * longint'(LP_COEF[k]);
		end
		// round half up, then clamp to Q1.15
		acc = (acc + (64'sd1 <<< 16)) >>> 17;
		if (acc > 32767) begin
			acc = 32767;
		end else if (acc < -32768) begin
			acc = -32768;
		end
		y = acc[15:0];
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Queue a run of samples of one shape
	task automatic queue_burst(input burst_kind_t kind, input int count);
		logic signed [15:0] level;
		int                 i;
		int                 c;
		level = 16'($urandom);
		for (i = 0; i < count; i++) begin
			// last sample of an aligned run lands on tap 0
			c = LP_COEF[(TAPS - 1) - (i % TAPS)];
			case (kind)
				AMP_NOISE:    pending_samples.push_back(16'($urandom));
				AMP_SMALL:    pending_samples.push_back(16'(int'($urandom_range(64)) - 32));
				AMP_HOLD:     pending_samples.push_back(level);
				AMP_MATCH_HI: pending_samples.push_back((c >= 0) ? SAMPLE_MAX : SAMPLE_MIN);
				AMP_MATCH_LO: pending_samples.push_back((c >= 0) ? SAMPLE_MIN : SAMPLE_MAX);
				default:      pending_samples.push_back((i % 2) ? level : -level);
			endcase
		end
	endtask

	task automatic queue_mix(input int count);
		int len;
		while (count > 0) begin
			len = $urandom_range(40, 5);
			if (len > count) begin
				len = count;
			end
			queue_burst(burst_kind_t'($urandom_range(5, 0)), len);
			count -= len;
		end
	endtask

	// Hold off until all samples are in and every output is back
	task automatic wait_quiet();
		do begin
			@(negedge clk);
		end while (pending_samples.size() != 0 || sample_in_valid
				|| expected_outputs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_decim(input logic [4:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		decim_reg  = value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		decim_writes++;
		@(negedge clk);
	endtask

	task automatic set_idle(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	// Sample driver
	always @(posedge clk) begin : drive_samples
		if (arst_n && (!sample_in_valid || sample_in_ready)) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				sample_in_valid <= 1'b1;
				sample_in       <= pending_samples.pop_front();
			end else begin
				sample_in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off
	always @(posedge clk) begin
		if (stall_start) begin
			stall_left <= STALL_CYCLES;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// Output ready
	always @(posedge clk) begin
		if (arst_n) begin
			filtered_out_ready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Predict on accepted samples, check accepted outputs
	always @(posedge clk) begin : watch_ports
		logic signed [15:0] want;
		if (arst_n) begin
			if (sample_in_valid && sample_in_ready) begin
				samples_in++;
				if (filter_sample(sample_in, want)) begin
					expected_outputs.push_back(want);
				end
			end
			if (filtered_out_valid && filtered_out_ready) begin
				outputs_seen++;
				if (expected_outputs.size() == 0) begin
					flag_mismatch($sformatf("unexpected output %0d", filtered_out));
				end else begin
					want = expected_outputs.pop_front();
					if (filtered_out !== want) begin
						flag_mismatch($sformatf("output #%0d filtered_out got %0d want %0d",
							outputs_seen, filtered_out, want));
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs still due",
				cycle_cnt, expected_outputs.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < TAPS; i++) begin
			delay_taps[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset factor, field extremes
		set_idle(18, 66);
		pending_samples.push_back(SAMPLE_MAX);
		pending_samples.push_back(SAMPLE_MIN);
		pending_samples.push_back(16'sd0);
		pending_samples.push_back(-16'sd1);
		pending_samples.push_back(16'sd1);
		pending_samples.push_back(SAMPLE_MAX);
		pending_samples.push_back(SAMPLE_MAX);
		pending_samples.push_back(SAMPLE_MIN);
		pending_samples.push_back(SAMPLE_MIN);
		pending_samples.push_back(16'sh5555);
		// leave the count at 7, then lower the factor below it
		queue_burst(AMP_NOISE, 7);
		wait_quiet();
		write_decim(5'd3);
		queue_burst(AMP_NOISE, 1);
		wait_quiet();
		// zero factor acts as one
		write_decim(5'd0);
		queue_burst(AMP_NOISE, 3);
		wait_quiet();

		// Every sample emits; positive clip while the receiver stalls
		write_decim(5'd1);
		queue_burst(AMP_MATCH_HI, TAPS);
		stall_start = 1'b1;
		@(negedge clk);
		stall_start = 1'b0;
		wait_quiet();
		// factor above the cap
		write_decim(5'd31);
		queue_mix(64);
		wait_quiet();

		set_idle(66, 18);
		write_decim(5'd0);
		queue_burst(AMP_MATCH_LO, TAPS);
		wait_quiet();
		write_decim(5'd17);
		queue_mix(48);
		wait_quiet();

		set_idle(0, 0);
		write_decim(5'd16);
		queue_mix(40);
		wait_quiet();
		for (i = 0; i < 3; i++) begin
			write_decim(5'($urandom_range(15, 2)));
			queue_mix(40);
			wait_quiet();
		end

		$display("Filtered %0d samples into %0d decimated outputs across %0d factor writes,",
			samples_in, outputs_seen, decim_writes);
		$display("including clipped runs, factor 0/1/16/17/31 and a long output stall.");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
